[rtl/itsdk_pkg.sv]
package itsdk_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int NDIG_MAX    = 10;

    localparam logic [7:0]  ZONE_ZERO = 8'h44;
    localparam logic [7:0]  ZONE_POS  = 8'h46;
    localparam logic [7:0]  ZONE_NEG  = 8'h42;
    localparam logic [7:0]  ASCII_0   = 8'h30;

    // floor(x / 10) == (x * RECIP10) >> RECIP_SHIFT for every 32-bit x
    localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    typedef struct packed {
        logic        neg;
        logic [31:0] mag;
    } t_item;

endpackage

[rtl/itsdk_front.sv]
module itsdk_front
    import itsdk_pkg::*;
(
    input  logic        i_cmd,
    input  logic [31:0] i_value,
    output t_item       o_item
);

    logic w_neg;

    // negative only when read as signed and the sign bit is set
    assign w_neg       = i_cmd & i_value[31];
    assign o_item.neg  = w_neg;
    assign o_item.mag  = w_neg ? (32'd0 - i_value) : i_value;

endmodule

[rtl/itsdk_queue.sv]
module itsdk_queue
    import itsdk_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    output logic  o_valid,
    input  logic  i_pop,
    output t_item o_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("queue pop while empty");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("queue count out of range");
`endif

endmodule

[rtl/itsdk_back.sv]
module itsdk_back
    import itsdk_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_item      i_q_item,
    output logic       o_q_pop,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,
    output logic       o_m_tlast
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_ZONE = 3'd2;
    localparam logic [2:0] S_EXP  = 3'd3;
    localparam logic [2:0] S_DIG  = 3'd4;

    logic [2:0]  r_state, n_state;
    logic        r_neg, n_neg;
    logic [31:0] r_mag, n_mag;
    logic [3:0]  r_ndig, n_ndig;
    logic [3:0]  r_tz, n_tz;
    logic        r_lead, n_lead;
    logic [3:0]  r_idx, n_idx;
    logic [3:0]  r_dig [NDIG_MAX];
    logic [3:0]  n_dig [NDIG_MAX];
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_out_data, n_out_data;
    logic        r_out_last, n_out_last;

    logic [63:0] w_prod;
    logic [31:0] w_quot;
    logic [31:0] w_rem_full;
    logic [3:0]  w_rem;
    logic        w_out_free;
    logic [3:0]  w_cur;
    logic [7:0]  w_exp;

    // divide by ten through the reciprocal, remainder by back-multiply
    assign w_prod     = 64'(r_mag) * 64'(RECIP10);
    assign w_quot     = 32'(w_prod >> RECIP_SHIFT);
    assign w_rem_full = r_mag - {w_quot[28:0], 3'b000} - {w_quot[30:0], 1'b0};
    assign w_rem      = w_rem_full[3:0];

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_cur      = r_dig[r_idx];
    assign w_exp      = 8'(r_ndig) - 8'd1;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

    always_comb begin
        n_state     = r_state;
        n_neg       = r_neg;
        n_mag       = r_mag;
        n_ndig      = r_ndig;
        n_tz        = r_tz;
        n_lead      = r_lead;
        n_idx       = r_idx;
        n_dig       = r_dig;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        o_q_pop     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_neg   = i_q_item.neg;
                    n_mag   = i_q_item.mag;
                    n_ndig  = '0;
                    n_tz    = '0;
                    n_lead  = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_mag != '0) begin
                    n_dig[r_ndig] = w_rem;
                    n_mag         = w_quot;
                    n_ndig        = r_ndig + 4'd1;
                    // count trailing zeros until the first nonzero digit
                    if (r_lead && w_rem == '0) begin
                        n_tz = r_tz + 4'd1;
                    end else begin
                        n_lead = 1'b0;
                    end
                end else begin
                    n_state = S_ZONE;
                end
            end
            S_ZONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    if (r_ndig == '0) begin
                        n_out_data = ZONE_ZERO;
                        n_out_last = 1'b1;
                        n_state    = S_IDLE;
                    end else begin
                        n_out_data = r_neg ? ZONE_NEG : ZONE_POS;
                        n_out_last = 1'b0;
                        n_state    = S_EXP;
                    end
                end
            end
            S_EXP: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_neg ? ~w_exp : w_exp;
                    n_out_last  = 1'b0;
                    n_idx       = r_ndig - 4'd1;
                    n_state     = S_DIG;
                end
            end
            S_DIG: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_last  = (r_idx == r_tz);
                    if (!r_neg) begin
                        n_out_data = ASCII_0 + 8'(w_cur);
                    end else if (r_idx == r_tz) begin
                        n_out_data = ASCII_0 + 8'd10 - 8'(w_cur);
                    end else begin
                        n_out_data = ASCII_0 + 8'd9 - 8'(w_cur);
                    end
                    if (r_idx == r_tz) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx - 4'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg      <= n_neg;
        r_mag      <= n_mag;
        r_ndig     <= n_ndig;
        r_tz       <= n_tz;
        r_lead     <= n_lead;
        r_idx      <= n_idx;
        r_dig      <= n_dig;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

`ifndef SYNTHESIS
    a_ndig_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_ndig <= 4'(NDIG_MAX)))
        else $error("digit count beyond ten");
    a_idx_above_tz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIG) |-> (r_idx >= r_tz && r_idx < r_ndig))
        else $error("digit index outside significant digits");
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |=> (r_out_valid && $stable(r_out_data)))
        else $error("output byte changed while stalled");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_state == S_IDLE && i_q_valid))
        else $error("queue popped outside idle");
`endif

endmodule

[rtl/int_to_sortable_decimal_key.sv]
// Encodes one 32-bit integer per input item (s_tuser = 1: signed, 0: unsigned)
// into an order-preserving decimal key sent out one byte per output item, with
// m_tlast on the final byte: zero gives 'D'; a positive value gives 'F', the
// digit count minus one, and its ASCII digits without trailing zeros; a
// negative value gives 'B', the complemented exponent and nine's-complemented
// digits with the last one ten's-complemented. A front stage forms sign and
// magnitude and drops the item into a QUEUE_DEPTH-entry queue, so new items are
// taken while the back end works. The back end loads an item from the queue,
// peels off one decimal digit per cycle through a divide-by-ten multiplier
// until the magnitude is zero, and then sends the key out byte by byte through
// the single output register, which holds its byte while m_tready is low. It
// takes the next item from the queue only after a key's last byte is issued.
module int_to_sortable_decimal_key
    import itsdk_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic        s_tuser,   // [0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] key_byte
    output logic        m_tlast
);

    t_item w_front_item;
    t_item w_q_item;
    logic  w_q_full;
    logic  w_q_valid;
    logic  w_q_pop;
    logic  w_push;

    // take an item whenever the queue has room
    assign s_tready = !w_q_full;
    assign w_push   = s_tvalid && !w_q_full;

    itsdk_front u_front (
        .i_cmd   (s_tuser),
        .i_value (s_tdata),
        .o_item  (w_front_item)
    );

    itsdk_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .i_pop   (w_q_pop),
        .o_item  (w_q_item)
    );

    // digit extraction and byte emission
    itsdk_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_q_item   (w_q_item),
        .o_q_pop    (w_q_pop),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

endmodule
